/* src/opwfd_pkg.sv */
package opwfd_pkg;

    // frame layout
    localparam int FRAME_BITS      = 14;
    localparam int CNT_W           = $clog2(FRAME_BITS + 2);
    localparam int IDX_W           = $clog2(FRAME_BITS);
    localparam int OVERLONG_COUNT  = FRAME_BITS + 1;

    // fixed leader high window
    localparam logic [15:0] LEADER_HIGH_MIN = 16'd1;
    localparam logic [15:0] LEADER_HIGH_MAX = 16'd370;

    // field widths
    localparam int TIME_W  = 16;
    localparam int DEV_W   = 6;
    localparam int HOUSE_W = 2;

    // frame bit positions of the house code
    localparam int HOUSE_LO_BIT = 10;
    localparam int HOUSE_HI_BIT = 9;

    // configuration register map
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam logic [REG_IDX_W-1:0] REG_LEADER_LOW_MIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_LOW_MAX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_MIN      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_MAX      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LONG_MIN       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LONG_MAX       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SILENCE_MIN    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SILENCE_MAX    = 3'd7;

    localparam logic [TIME_W-1:0] CFG_RESET [NUM_REGS] = '{
        16'd110, 16'd155, 16'd25, 16'd40, 16'd85, 16'd100, 16'd2200, 16'd6000
    };

    // phase codes of the frame tracker
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_LEADER    = 2'd1;
    localparam logic [1:0] PH_WAIT_HIGH = 2'd2;
    localparam logic [1:0] PH_WAIT_LOW  = 2'd3;

    // classified pulse passed from front to back
    typedef struct packed {
        logic level;
        logic lead_high;
        logic lead_low;
        logic is_short;
        logic is_long;
        logic is_silence;
    } t_token;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

/* src/opwfd_front.sv */
module opwfd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [opwfd_pkg::REG_IDX_W-1:0]    i_cfg_index,
    input  logic [opwfd_pkg::TIME_W-1:0]       i_cfg_data,
    input  logic                               i_level,
    input  logic [opwfd_pkg::TIME_W-1:0]       i_pulse_time,
    output opwfd_pkg::t_token                  o_token
);

    logic [opwfd_pkg::TIME_W-1:0] r_cfg [opwfd_pkg::NUM_REGS];

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < opwfd_pkg::NUM_REGS; i++) begin
                r_cfg[i] <= opwfd_pkg::CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // inclusive window compares
    always_comb begin
        o_token.level      = i_level;
        o_token.lead_high  = (i_pulse_time >= opwfd_pkg::LEADER_HIGH_MIN) &&
                             (i_pulse_time <= opwfd_pkg::LEADER_HIGH_MAX);
        o_token.lead_low   = (i_pulse_time >= r_cfg[opwfd_pkg::REG_LEADER_LOW_MIN]) &&
                             (i_pulse_time <= r_cfg[opwfd_pkg::REG_LEADER_LOW_MAX]);
        o_token.is_short   = (i_pulse_time >= r_cfg[opwfd_pkg::REG_SHORT_MIN]) &&
                             (i_pulse_time <= r_cfg[opwfd_pkg::REG_SHORT_MAX]);
        o_token.is_long    = (i_pulse_time >= r_cfg[opwfd_pkg::REG_LONG_MIN]) &&
                             (i_pulse_time <= r_cfg[opwfd_pkg::REG_LONG_MAX]);
        o_token.is_silence = (i_pulse_time >= r_cfg[opwfd_pkg::REG_SILENCE_MIN]) &&
                             (i_pulse_time <= r_cfg[opwfd_pkg::REG_SILENCE_MAX]);
    end

endmodule

/* src/opwfd_queue.sv */
module opwfd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  opwfd_pkg::t_token  i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output opwfd_pkg::t_token  o_data
);

    opwfd_pkg::t_token                 r_mem [opwfd_pkg::QUEUE_DEPTH];
    logic [opwfd_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [opwfd_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [opwfd_pkg::QCNT_W-1:0]      r_count;
    logic                              w_push;
    logic                              w_pop;

    assign o_full  = (r_count == opwfd_pkg::QCNT_W'(opwfd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= opwfd_pkg::QCNT_W'(opwfd_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

/* src/opwfd_back.sv */
module opwfd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  opwfd_pkg::t_token                  i_token,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [opwfd_pkg::DEV_W-1:0]        o_device_number,
    output logic [opwfd_pkg::HOUSE_W-1:0]      o_house_code
);

    logic [1:0]                            r_phase;
    logic [1:0]                            n_phase;
    logic [opwfd_pkg::CNT_W-1:0]           r_bit_count;
    logic [opwfd_pkg::CNT_W-1:0]           n_bit_count;
    logic [opwfd_pkg::FRAME_BITS-1:0]      r_frame_bits;
    logic [opwfd_pkg::FRAME_BITS-1:0]      n_frame_bits;
    logic                                  r_out_valid;
    logic [opwfd_pkg::DEV_W-1:0]           r_device_number;
    logic [opwfd_pkg::HOUSE_W-1:0]         r_house_code;
    logic                                  w_emit;
    logic                                  w_store;
    logic                                  w_store_bit;

    assign o_pop           = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid         = r_out_valid;
    assign o_device_number = r_device_number;
    assign o_house_code    = r_house_code;

    // frame tracker next state
    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_frame_bits = r_frame_bits;
        w_emit       = 1'b0;
        w_store      = 1'b0;
        w_store_bit  = 1'b0;
        if (i_token.level) begin
            if (r_phase == opwfd_pkg::PH_IDLE && i_token.lead_high) begin
                n_phase = opwfd_pkg::PH_LEADER;
            end else if (r_phase == opwfd_pkg::PH_WAIT_HIGH && i_token.is_short) begin
                n_phase = opwfd_pkg::PH_WAIT_LOW;
            end else begin
                n_phase      = opwfd_pkg::PH_IDLE;
                n_bit_count  = '0;
                n_frame_bits = '0;
            end
        end else begin
            if (r_phase == opwfd_pkg::PH_LEADER && i_token.lead_low) begin
                n_phase = opwfd_pkg::PH_WAIT_HIGH;
            end else if (r_phase == opwfd_pkg::PH_WAIT_LOW && i_token.is_short) begin
                n_phase     = opwfd_pkg::PH_WAIT_HIGH;
                w_store     = 1'b1;
                w_store_bit = 1'b1;
            end else if (r_phase == opwfd_pkg::PH_WAIT_LOW && i_token.is_long) begin
                n_phase     = opwfd_pkg::PH_WAIT_HIGH;
                w_store     = 1'b1;
                w_store_bit = 1'b0;
            end else begin
                w_emit = (r_phase == opwfd_pkg::PH_WAIT_LOW) && i_token.is_silence &&
                         (r_bit_count == opwfd_pkg::CNT_W'(opwfd_pkg::FRAME_BITS));
                n_phase      = opwfd_pkg::PH_IDLE;
                n_bit_count  = '0;
                n_frame_bits = '0;
            end
        end
        // bit store with saturation
        if (w_store) begin
            if (r_bit_count < opwfd_pkg::CNT_W'(opwfd_pkg::FRAME_BITS)) begin
                n_frame_bits[r_bit_count[opwfd_pkg::IDX_W-1:0]] = w_store_bit;
                n_bit_count = r_bit_count + 1'b1;
            end else begin
                n_bit_count = opwfd_pkg::CNT_W'(opwfd_pkg::OVERLONG_COUNT);
            end
        end
    end

    // tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= opwfd_pkg::PH_IDLE;
            r_bit_count  <= '0;
            r_frame_bits <= '0;
        end else if (o_pop) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_frame_bits <= n_frame_bits;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_device_number <= r_frame_bits[opwfd_pkg::DEV_W-1:0];
            r_house_code    <= {r_frame_bits[opwfd_pkg::HOUSE_HI_BIT],
                                r_frame_bits[opwfd_pkg::HOUSE_LO_BIT]};
        end
    end

`ifndef SYNTHESIS
    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_pop)
        else $error("token consumed while result stalled");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= opwfd_pkg::CNT_W'(opwfd_pkg::OVERLONG_COUNT))
        else $error("bit count beyond overlong mark");
    a_emit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_emit) |=> (r_phase == opwfd_pkg::PH_IDLE && r_bit_count == '0 && o_valid))
        else $error("result not followed by restart");
`endif

endmodule

/* src/ook_pulse_width_frame_decoder.sv */
// On-off-keyed pulse-width frame decoder. Each transfer on the input carries one
// pulse (level and duration in ticks); a frame is a leader high, a leader low and
// then pairs of a short high and a short (bit 1) or long (bit 0) low, closed by a
// terminator silence. A frame of exactly 14 bits yields one transfer on the output
// with the device number and house code; anything else yields nothing. One pulse is
// taken every clock cycle while input ready is high: the window compares run on the
// incoming pulse, a two-entry queue holds the classified pulse, and the frame tracker
// consumes one entry per cycle unless stalled, so output valid rises at the edge that
// pops the terminator pulse. The tracker stalls only while a finished result waits
// on the output; the queue then fills and input ready drops. Window registers are
// to be written through the plain write port while idle; the block does not enforce it.
module ook_pulse_width_frame_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [opwfd_pkg::REG_IDX_W-1:0]    i_cfg_index,
    input  logic [opwfd_pkg::TIME_W-1:0]       i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_level,
    input  logic [opwfd_pkg::TIME_W-1:0]       i_pulse_time,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [opwfd_pkg::DEV_W-1:0]        o_device_number,
    output logic [opwfd_pkg::HOUSE_W-1:0]      o_house_code
);

    opwfd_pkg::t_token w_in_token;
    opwfd_pkg::t_token w_q_token;
    logic              w_q_full;
    logic              w_q_valid;
    logic              w_pop;

    assign o_ready = !w_q_full;

    // classify incoming pulse
    opwfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_level      (i_level),
        .i_pulse_time (i_pulse_time),
        .o_token      (w_in_token)
    );

    // decoupling queue
    opwfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (w_in_token),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_token)
    );

    // frame tracker and result register
    opwfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_token         (w_q_token),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_device_number (o_device_number),
        .o_house_code    (o_house_code)
    );

endmodule

/* sim/ook_pulse_width_frame_decoder_test.sv */
`timescale 1ns / 1ps

module ook_pulse_width_frame_decoder_test;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int BACKLOG       = 8;

    typedef struct packed {
        logic                         level;
        logic [opwfd_pkg::TIME_W-1:0] dur;
    } t_pulse;

    typedef struct packed {
        logic [opwfd_pkg::DEV_W-1:0]   dev;
        logic [opwfd_pkg::HOUSE_W-1:0] house;
    } t_frame_code;

    // block ports
    logic                            i_clk        = 1'b0;
    logic                            i_rst_n      = 1'b0;
    logic                            i_cfg_we     = 1'b0;
    logic [opwfd_pkg::REG_IDX_W-1:0] i_cfg_index  = '0;
    logic [opwfd_pkg::TIME_W-1:0]    i_cfg_data   = '0;
    logic                            i_valid      = 1'b0;
    logic                            o_ready;
    logic                            i_level      = 1'b0;
    logic [opwfd_pkg::TIME_W-1:0]    i_pulse_time = '0;
    logic                            o_valid;
    logic                            i_ready      = 1'b0;
    logic [opwfd_pkg::DEV_W-1:0]     o_device_number;
    logic [opwfd_pkg::HOUSE_W-1:0]   o_house_code;

    // stimulus and scoreboard
    t_pulse          pending_pulses [$];
    t_frame_code     expected_codes [$];
    t_pulse          next_pulse;
    t_frame_code     want_code;
    logic [opwfd_pkg::DEV_W-1:0]   pred_dev;
    logic [opwfd_pkg::HOUSE_W-1:0] pred_house;
    int              pulses_queued = 0;
    int              codes_seen    = 0;
    int              error_count   = 0;
    int              idle_cycles   = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              corrupt_permille = 8;

    // predictor copy of the window registers and the frame tracker
    logic [opwfd_pkg::TIME_W-1:0]     win_cfg [opwfd_pkg::NUM_REGS];
    logic [1:0]                       trk_phase;
    int                               trk_bits;
    logic [opwfd_pkg::FRAME_BITS-1:0] frame_word;

    ook_pulse_width_frame_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_level         (i_level),
        .i_pulse_time    (i_pulse_time),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_device_number (o_device_number),
        .o_house_code    (o_house_code)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // frame tracker prediction
    // ---------------------------------------------------------------
    function automatic bit in_win(input logic [opwfd_pkg::TIME_W-1:0] t, lo, hi);
        return (t >= lo) && (t <= hi);
    endfunction

    function automatic void clear_frame();
        trk_phase  = opwfd_pkg::PH_IDLE;
        trk_bits   = 0;
        frame_word = '0;
    endfunction

    // bits past the frame length are dropped and the count sticks at overlong
    function automatic void add_bit(input logic b);
        if (trk_bits < opwfd_pkg::FRAME_BITS) begin
            frame_word[trk_bits] = b;
            trk_bits++;
        end else begin
            trk_bits = opwfd_pkg::OVERLONG_COUNT;
        end
    endfunction

    function automatic bit decode_pulse(input logic lvl,
                                        input logic [opwfd_pkg::TIME_W-1:0] t,
                                        output logic [opwfd_pkg::DEV_W-1:0] dev,
                                        output logic [opwfd_pkg::HOUSE_W-1:0] house);
        bit fired;
        fired = 1'b0;
        dev   = '0;
        house = '0;
        if (lvl) begin
            if (trk_phase == opwfd_pkg::PH_IDLE &&
                in_win(t, opwfd_pkg::LEADER_HIGH_MIN, opwfd_pkg::LEADER_HIGH_MAX)) begin
                trk_phase = opwfd_pkg::PH_LEADER;
            end else if (trk_phase == opwfd_pkg::PH_WAIT_HIGH &&
                         in_win(t, win_cfg[opwfd_pkg::REG_SHORT_MIN],
                                win_cfg[opwfd_pkg::REG_SHORT_MAX])) begin
                trk_phase = opwfd_pkg::PH_WAIT_LOW;
            end else begin
                clear_frame();
            end
        end else if (trk_phase == opwfd_pkg::PH_LEADER &&
                     in_win(t, win_cfg[opwfd_pkg::REG_LEADER_LOW_MIN],
                            win_cfg[opwfd_pkg::REG_LEADER_LOW_MAX])) begin
            trk_phase = opwfd_pkg::PH_WAIT_HIGH;
        end else if (trk_phase == opwfd_pkg::PH_WAIT_LOW &&
                     in_win(t, win_cfg[opwfd_pkg::REG_SHORT_MIN],
                            win_cfg[opwfd_pkg::REG_SHORT_MAX])) begin
            add_bit(1'b1);
            trk_phase = opwfd_pkg::PH_WAIT_HIGH;
        end else if (trk_phase == opwfd_pkg::PH_WAIT_LOW &&
                     in_win(t, win_cfg[opwfd_pkg::REG_LONG_MIN],
                            win_cfg[opwfd_pkg::REG_LONG_MAX])) begin
            add_bit(1'b0);
            trk_phase = opwfd_pkg::PH_WAIT_HIGH;
        end else begin
            // terminator closes a frame of exactly the right length
            if (trk_phase == opwfd_pkg::PH_WAIT_LOW && trk_bits == opwfd_pkg::FRAME_BITS &&
                in_win(t, win_cfg[opwfd_pkg::REG_SILENCE_MIN],
                       win_cfg[opwfd_pkg::REG_SILENCE_MAX])) begin
                fired = 1'b1;
                dev   = frame_word[opwfd_pkg::DEV_W-1:0];
                house = {frame_word[opwfd_pkg::HOUSE_HI_BIT],
                         frame_word[opwfd_pkg::HOUSE_LO_BIT]};
            end
            clear_frame();
        end
        return fired;
    endfunction

    // ---------------------------------------------------------------
    // pulse driver
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_pulses.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                next_pulse = pending_pulses.pop_front();
                i_valid      <= 1'b1;
                i_level      <= next_pulse.level;
                i_pulse_time <= next_pulse.dur;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // monitor: check results, then predict from the accepted pulse
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            idle_cycles = 0;
        end else begin
            if (o_valid && i_ready) begin
                codes_seen++;
                if (expected_codes.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual dev %0d house %0d",
                             $time, o_device_number, o_house_code);
                    error_count++;
                end else begin
                    want_code = expected_codes.pop_front();
                    if (o_device_number !== want_code.dev) begin
                        $display("%0t: device_number expected %0d actual %0d",
                                 $time, want_code.dev, o_device_number);
                        error_count++;
                    end
                    if (o_house_code !== want_code.house) begin
                        $display("%0t: house_code expected %0d actual %0d",
                                 $time, want_code.house, o_house_code);
                        error_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                if (decode_pulse(i_level, i_pulse_time, pred_dev, pred_house))
                    expected_codes.push_back('{dev: pred_dev, house: pred_house});
            end
            // watchdog on transfers in either direction
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_pulse(input logic lvl, input logic [opwfd_pkg::TIME_W-1:0] dur);
        pending_pulses.push_back('{level: lvl, dur: dur});
        pulses_queued++;
    endtask

    // random duration inside a window, edges favored; anything if the window is empty
    function automatic logic [opwfd_pkg::TIME_W-1:0] pick(
        input logic [opwfd_pkg::TIME_W-1:0] lo, hi);
        if (lo > hi)
            return opwfd_pkg::TIME_W'($urandom_range(65535, 0));
        case ($urandom_range(7, 0))
            0: return lo;
            1: return hi;
            default: return opwfd_pkg::TIME_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // frame pulse, now and then damaged
    task automatic queue_frame_pulse(input logic lvl,
                                     input logic [opwfd_pkg::TIME_W-1:0] dur);
        if ($urandom_range(999, 0) < corrupt_permille) begin
            dur = opwfd_pkg::TIME_W'($urandom_range(65535, 0));
            if ($urandom_range(3, 0) == 0)
                lvl = ~lvl;
        end
        push_pulse(lvl, dur);
    endtask

    task automatic push_frame(input int nbits);
        bit b;
        queue_frame_pulse(1'b1, pick(opwfd_pkg::LEADER_HIGH_MIN, opwfd_pkg::LEADER_HIGH_MAX));
        queue_frame_pulse(1'b0, pick(win_cfg[opwfd_pkg::REG_LEADER_LOW_MIN],
                                     win_cfg[opwfd_pkg::REG_LEADER_LOW_MAX]));
        for (int k = 0; k < nbits; k++) begin
            queue_frame_pulse(1'b1, pick(win_cfg[opwfd_pkg::REG_SHORT_MIN],
                                         win_cfg[opwfd_pkg::REG_SHORT_MAX]));
            b = 1'($urandom_range(1, 0));
            if (b)
                queue_frame_pulse(1'b0, pick(win_cfg[opwfd_pkg::REG_SHORT_MIN],
                                             win_cfg[opwfd_pkg::REG_SHORT_MAX]));
            else
                queue_frame_pulse(1'b0, pick(win_cfg[opwfd_pkg::REG_LONG_MIN],
                                             win_cfg[opwfd_pkg::REG_LONG_MAX]));
        end
        queue_frame_pulse(1'b1, pick(win_cfg[opwfd_pkg::REG_SHORT_MIN],
                                     win_cfg[opwfd_pkg::REG_SHORT_MAX]));
        queue_frame_pulse(1'b0, pick(win_cfg[opwfd_pkg::REG_SILENCE_MIN],
                                     win_cfg[opwfd_pkg::REG_SILENCE_MAX]));
    endtask

    // wait until every pulse is sent and every result is back, then let the block settle
    task automatic drain();
        while (pending_pulses.size() != 0 || i_valid || expected_codes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // write all window registers on consecutive edges
    task automatic set_windows(input logic [opwfd_pkg::TIME_W-1:0] w [opwfd_pkg::NUM_REGS]);
        for (int r = 0; r < opwfd_pkg::NUM_REGS; r++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= opwfd_pkg::REG_IDX_W'(r);
            i_cfg_data  <= w[r];
            win_cfg[r] = w[r];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // mostly well formed frames, some noise; runs until enough codes or 4x quota pulses
    task automatic run_random(input int quota, input int want_codes);
        int first_pulse;
        int first_code;
        int nbits;
        first_pulse = pulses_queued;
        first_code  = codes_seen;
        while ((pulses_queued - first_pulse < quota || codes_seen - first_code < want_codes)
               && pulses_queued - first_pulse < 4 * quota) begin
            if ($urandom_range(99, 0) < 85) begin
                if ($urandom_range(99, 0) < 70)
                    nbits = opwfd_pkg::FRAME_BITS;
                else
                    nbits = $urandom_range(opwfd_pkg::FRAME_BITS + 3, 0);
                push_frame(nbits);
            end else begin
                repeat ($urandom_range(3, 1))
                    push_pulse(1'($urandom_range(1, 0)),
                               opwfd_pkg::TIME_W'($urandom_range(65535, 0)));
            end
            while (pending_pulses.size() > BACKLOG) @(negedge i_clk);
        end
        drain();
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        logic [opwfd_pkg::TIME_W-1:0] plan [opwfd_pkg::NUM_REGS];
        win_cfg = opwfd_pkg::CFG_RESET;
        send_idle_pct = 7;
        recv_idle_pct = 75;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // field extremes while idle
        push_pulse(1'b1, 16'hFFFF);
        push_pulse(1'b0, 16'h0000);
        push_pulse(1'b1, 16'h0000);
        push_pulse(1'b0, 16'hFFFF);
        // short frame of two bits on window edges, no result
        push_pulse(1'b1, 16'd1);
        push_pulse(1'b0, 16'd110);
        push_pulse(1'b1, 16'd25);
        push_pulse(1'b0, 16'd40);
        push_pulse(1'b1, 16'd40);
        push_pulse(1'b0, 16'd85);
        push_pulse(1'b1, 16'd25);
        push_pulse(1'b0, 16'd2200);
        // high just outside the short window restarts the tracker
        push_pulse(1'b1, 16'd370);
        push_pulse(1'b0, 16'd155);
        push_pulse(1'b1, 16'd41);
        // terminator with no bits at all
        push_pulse(1'b1, 16'd300);
        push_pulse(1'b0, 16'd155);
        push_pulse(1'b1, 16'd30);
        push_pulse(1'b0, 16'd6000);
        drain();

        // reset windows, with a full pause halfway
        run_random(200, 5);
        run_random(200, 5);

        // random windows
        send_idle_pct = 75;
        recv_idle_pct = 7;
        for (int r = 0; r < opwfd_pkg::NUM_REGS; r += 2) begin
            plan[r]     = opwfd_pkg::TIME_W'($urandom_range(3000, 0));
            plan[r + 1] = plan[r] + opwfd_pkg::TIME_W'($urandom_range(800, 0));
        end
        set_windows(plan);
        run_random(300, 5);

        // wide overlapping windows reaching both ends of the range
        plan = '{16'd0, 16'd65535, 16'd20, 16'd60, 16'd40, 16'd120, 16'd100, 16'd65535};
        set_windows(plan);
        run_random(200, 5);

        // every configurable window empty: nothing but restarts
        send_idle_pct = 0;
        recv_idle_pct = 0;
        plan = '{16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0};
        set_windows(plan);
        run_random(100, 0);

        // single-point windows at the extremes
        plan = '{16'd0, 16'd0, 16'd65535, 16'd65535, 16'd1, 16'd1, 16'd65534, 16'd65534};
        set_windows(plan);
        run_random(200, 5);

        // back to the reset windows
        set_windows(opwfd_pkg::CFG_RESET);
        run_random(200, 10);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
